### design/fire_effect_cell_update_top_assert.svh
// Assertion macros for the fire cell engine checker.
`ifndef FIRE_EFFECT_CELL_UPDATE_TOP_ASSERT_SVH
`define FIRE_EFFECT_CELL_UPDATE_TOP_ASSERT_SVH

// Same-cycle implication, held off while in reset.
`define FEC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fire cell engine: check failed");

// Implication checked in the next cycle.
`define FEC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fire cell engine: check failed");

`endif

### design/fec_pkg.sv
// ----------------------------------------------------------------------------
// fec_pkg
// Shared constants, field widths and the colour palette of the fire cell engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fec_pkg;

    localparam int GRID_WIDTH  = 240;
    localparam int GRID_HEIGHT = 270;
    localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W      = $clog2(CELLS);

    localparam int HEAT_MAX = 36;
    localparam int LEVELS   = 37;

    localparam int HEAT_W = 6;
    localparam int COL_W  = 8;
    localparam int ROW_W  = 9;
    localparam int RND_W  = 2;
    localparam int CH_W   = 8;
    localparam int IDX_W  = $clog2(LEVELS);

    localparam logic KIND_SPREAD = 1'b0;
    localparam logic KIND_RENDER = 1'b1;

    typedef logic [3*CH_W-1:0] t_rgb;
    typedef logic [LEVELS-1:0][3*CH_W-1:0] t_palette;

    // gradient stops, red in the top byte
    localparam logic [3:0][3*CH_W-1:0] STOPS = {
        24'hFFFFFF, 24'hFDD958, 24'hFF4600, 24'h000000
    };

    function automatic t_palette build_palette();
        t_palette p;
        int seg;
        int k;
        int a;
        int b;
        p = '0;
        for (int i = 0; i < LEVELS; i++) begin
            seg = (3 * i) / LEVELS;
            k   = (3 * i) % LEVELS;
            for (int c = 0; c < 3; c++) begin
                a = int'(STOPS[seg][(2 - c) * CH_W +: CH_W]);
                b = int'(STOPS[seg + 1][(2 - c) * CH_W +: CH_W]);
                p[i][(2 - c) * CH_W +: CH_W] = CH_W'((a * (LEVELS - k) + b * k) / LEVELS);
            end
        end
        return p;
    endfunction

    localparam t_palette PALETTE = build_palette();

endpackage

`default_nettype wire

### design/fec_ram.sv
// ----------------------------------------------------------------------------
// fec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/fec_palette.sv
// ----------------------------------------------------------------------------
// fec_palette
// Heat to RGB lookup; out-of-range heat clamps to the hottest colour.
// ----------------------------------------------------------------------------
`default_nettype none

module fec_palette (
    input  wire logic [fec_pkg::HEAT_W-1:0] i_heat,
    output logic      [fec_pkg::CH_W-1:0]   o_red,
    output logic      [fec_pkg::CH_W-1:0]   o_green,
    output logic      [fec_pkg::CH_W-1:0]   o_blue
);

    logic [fec_pkg::IDX_W-1:0] w_idx;
    fec_pkg::t_rgb             w_rgb;

    always_comb begin
        if (32'(i_heat) > fec_pkg::HEAT_MAX) begin
            w_idx = fec_pkg::IDX_W'(fec_pkg::HEAT_MAX);
        end else begin
            w_idx = fec_pkg::IDX_W'(i_heat);
        end
        w_rgb = fec_pkg::PALETTE[w_idx];
    end

    assign o_red   = w_rgb[3*fec_pkg::CH_W-1:2*fec_pkg::CH_W];
    assign o_green = w_rgb[2*fec_pkg::CH_W-1:fec_pkg::CH_W];
    assign o_blue  = w_rgb[fec_pkg::CH_W-1:0];

endmodule

`default_nettype wire

### design/fire_effect_cell_update_top.sv
// ----------------------------------------------------------------------------
// fire_effect_cell_update_top
// Fire effect heat grid: spread and render requests on a cell RAM with one write and one read port.
// ----------------------------------------------------------------------------
// After reset the block is busy while it clears the heat RAM, cell by
// cell, and lights the bottom row. Each request then passes through
// accept, RAM read and modify/write-back; busy is high for the
// last two. The result appears on the o_ ports with o_done high for exactly
// one cycle, the cycle after the write-back, and must be taken then: there
// is no back-pressure. A new request may be accepted in that same cycle.
// The registered RAM read is what calls for the separate read step.
`default_nettype none

module fire_effect_cell_update_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_kind,
    input  wire logic [fec_pkg::COL_W-1:0]  i_cell_column,
    input  wire logic [fec_pkg::ROW_W-1:0]  i_cell_row,
    input  wire logic [fec_pkg::RND_W-1:0]  i_rnd,
    output logic                            o_done,
    output logic      [fec_pkg::HEAT_W-1:0] o_heat,
    output logic      [fec_pkg::CH_W-1:0]   o_red,
    output logic      [fec_pkg::CH_W-1:0]   o_green,
    output logic      [fec_pkg::CH_W-1:0]   o_blue,
    output logic      [fec_pkg::ROW_W-1:0]  o_top_row
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    localparam logic [fec_pkg::ADDR_W-1:0] LAST_ADDR =
        fec_pkg::ADDR_W'(fec_pkg::CELLS - 1);
    localparam logic [fec_pkg::ADDR_W-1:0] BOTTOM_ADDR =
        fec_pkg::ADDR_W'((fec_pkg::GRID_HEIGHT - 1) * fec_pkg::GRID_WIDTH);
    localparam logic [fec_pkg::ADDR_W-1:0] ROW_STEP =
        fec_pkg::ADDR_W'(fec_pkg::GRID_WIDTH);

    t_state                       r_state;
    logic [fec_pkg::ADDR_W-1:0]   r_clr_addr;
    logic                         r_kind;
    logic [fec_pkg::ROW_W-1:0]    r_row;
    logic [fec_pkg::COL_W-1:0]    r_col;
    logic [fec_pkg::RND_W-1:0]    r_rnd;
    logic                         r_inside;
    logic [fec_pkg::ADDR_W-1:0]   r_from;
    logic [fec_pkg::ROW_W-1:0]    r_top;

    logic [fec_pkg::ADDR_W-1:0]   w_from;
    logic [fec_pkg::HEAT_W-1:0]   w_rd_heat;
    logic [fec_pkg::CH_W-1:0]     w_pal_r;
    logic [fec_pkg::CH_W-1:0]     w_pal_g;
    logic [fec_pkg::CH_W-1:0]     w_pal_b;
    logic [fec_pkg::ADDR_W:0]     w_base;
    logic [fec_pkg::ADDR_W:0]     w_sub;
    logic [fec_pkg::HEAT_W-1:0]   w_dec;

    logic                         w_we;
    logic [fec_pkg::ADDR_W-1:0]   w_waddr;
    logic [fec_pkg::HEAT_W-1:0]   w_wdata;

    logic [fec_pkg::HEAT_W-1:0]   n_heat;
    logic [fec_pkg::CH_W-1:0]     n_red;
    logic [fec_pkg::CH_W-1:0]     n_green;
    logic [fec_pkg::CH_W-1:0]     n_blue;
    logic [fec_pkg::ROW_W-1:0]    n_top;

    // linear cell index, only meaningful when the cell is inside the grid
    assign w_from = fec_pkg::ADDR_W'(32'(r_row) * fec_pkg::GRID_WIDTH + 32'(r_col));

    fec_ram #(
        .WIDTH (fec_pkg::HEAT_W),
        .DEPTH (fec_pkg::CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_from),
        .o_rdata (w_rd_heat)
    );

    fec_palette u_palette (
        .i_heat  (w_rd_heat),
        .o_red   (w_pal_r),
        .o_green (w_pal_g),
        .o_blue  (w_pal_b)
    );

    // spread target = from + 1 - width - rnd, dropped when it would go negative
    assign w_base = {1'b0, r_from} + (fec_pkg::ADDR_W + 1)'(1);
    assign w_sub  = (fec_pkg::ADDR_W + 1)'(fec_pkg::GRID_WIDTH) +
                    (fec_pkg::ADDR_W + 1)'(r_rnd);
    assign w_dec  = fec_pkg::HEAT_W'(r_rnd[0]);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_addr;
        w_wdata = '0;
        n_heat  = '0;
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        n_top   = r_top;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = (r_clr_addr >= BOTTOM_ADDR) ?
                          fec_pkg::HEAT_W'(fec_pkg::HEAT_MAX) : '0;
            end
            S_EXEC: begin
                if (r_inside) begin
                    if (r_kind == fec_pkg::KIND_RENDER) begin
                        n_heat  = w_rd_heat;
                        n_red   = w_pal_r;
                        n_green = w_pal_g;
                        n_blue  = w_pal_b;
                        if (w_rd_heat != '0 && r_row < r_top) begin
                            n_top = r_row;
                        end
                    end else if (r_row != '0) begin
                        if (w_rd_heat == '0) begin
                            // cold cell: extinguish the cell above
                            w_we    = 1'b1;
                            w_waddr = r_from - ROW_STEP;
                            w_wdata = '0;
                        end else begin
                            n_heat  = (w_rd_heat > w_dec) ? w_rd_heat - w_dec : '0;
                            w_we    = (w_base >= w_sub);
                            w_waddr = fec_pkg::ADDR_W'(w_base - w_sub);
                            w_wdata = n_heat;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_top      <= fec_pkg::ROW_W'(fec_pkg::GRID_HEIGHT);
            o_done     <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + fec_pkg::ADDR_W'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_kind   <= i_kind;
                        r_row    <= i_cell_row;
                        r_col    <= i_cell_column;
                        r_rnd    <= i_rnd;
                        r_inside <= (32'(i_cell_column) < fec_pkg::GRID_WIDTH) &&
                                    (32'(i_cell_row) < fec_pkg::GRID_HEIGHT);
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_from  <= w_from;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    o_heat  <= n_heat;
                    o_red   <= n_red;
                    o_green <= n_green;
                    o_blue  <= n_blue;
                    r_top   <= n_top;
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (r_state != S_IDLE) || !i_rst_n;
    assign o_top_row = r_top;

endmodule

`default_nettype wire

### design/fec_checker.sv
// ----------------------------------------------------------------------------
// fec_checker
// Port-level timing checks for the fire cell engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fire_effect_cell_update_top_assert.svh"

module fec_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_done,
    input wire logic [fec_pkg::ROW_W-1:0]  o_top_row
);

    // a request is answered once it has passed through the read and execute states
    `FEC_ASSERT_NOW(a_done_latency, start && !busy, ##3 o_done)

    // engine is occupied right after taking a request
    `FEC_ASSERT_NEXT(a_busy_after_req, start && !busy, busy && !o_done)

    // the result cycle is also a cycle in which a new request can be taken
    `FEC_ASSERT_NOW(a_idle_on_done, o_done, !busy)

    // top-row tracker only ever moves up the grid
    `FEC_ASSERT_NOW(a_top_monotonic, $past(i_rst_n), o_top_row <= $past(o_top_row))

endmodule

bind fire_effect_cell_update_top fec_checker u_fec_checker (.*);

`default_nettype wire
